// File: sv/ocl_pkg.sv
// ----------------------------------------------------------------------------
// Ordered character list package
// Sizes, request and status codes, and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package ocl_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CHAR_W = 8;
    localparam int POS_W  = 8;
    localparam int REQ_W  = 2;
    localparam int LEN_W  = 5;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    typedef struct packed {
        logic    capture;
        logic    append;
        logic    read_pos;
        logic    start_scan;
        logic    scan_next;
        logic    shift_step;
        logic    dec_count;
        logic    set_res;
        logic    res_use_rdata;
        status_t res_status;
        logic    load_out;
    } ocl_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             full;
        logic             empty;
        logic             pos_out;
        logic             match;
        logic             more;
        logic             more2;
    } ocl_stat_t;

endpackage

// File: sv/ocl_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ocl_ram #(
    parameter int WIDTH = 8,
    parameter int WORDS = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(WORDS)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(WORDS)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [WORDS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/ocl_dp.sv
// ----------------------------------------------------------------------------
// Ordered character list datapath
// Request registers, entry count, scan index, entry RAM and result registers.
// ----------------------------------------------------------------------------
module ocl_dp (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [ocl_pkg::REQ_W-1:0]  req_type_in,
    input  logic [ocl_pkg::CHAR_W-1:0] char_in,
    input  logic [ocl_pkg::POS_W-1:0]  position_in,
    input  ocl_pkg::ocl_cmd_t          cmd,
    output ocl_pkg::ocl_stat_t         stat,
    output logic [1:0]                 status_out,
    output logic [ocl_pkg::CHAR_W-1:0] char_out,
    output logic [ocl_pkg::LEN_W-1:0]  length_out
);
    import ocl_pkg::*;

    logic [REQ_W-1:0]  req_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  idx_reg;
    status_t           res_status_reg;
    logic [CHAR_W-1:0] res_char_reg;
    logic [1:0]        out_status_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic [LEN_W-1:0]  out_len_reg;

    logic [CNT_W-1:0]  idx_inc;
    logic [CNT_W:0]    idx_inc2;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic [CHAR_W-1:0] ram_rdata;

    assign idx_inc  = idx_reg + 1'b1;
    assign idx_inc2 = {1'b0, idx_inc} + 1'b1;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = count_reg[ADDR_W-1:0];
        ram_wdata = char_reg;
        ram_raddr = idx_inc[ADDR_W-1:0];
        if (cmd.append) begin
            ram_we = 1'b1;
        end else if (cmd.shift_step) begin
            ram_we    = 1'b1;
            ram_waddr = idx_reg[ADDR_W-1:0];
            ram_wdata = ram_rdata;
            ram_raddr = idx_inc2[ADDR_W-1:0];
        end else if (cmd.read_pos) begin
            ram_raddr = pos_reg[ADDR_W-1:0];
        end else if (cmd.start_scan) begin
            ram_raddr = '0;
        end
    end

    ocl_ram #(
        .WIDTH (CHAR_W),
        .WORDS (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        stat.req_type = req_reg;
        stat.full     = (count_reg == CNT_W'(DEPTH));
        stat.empty    = (count_reg == '0);
        stat.pos_out  = (CMP_W'(pos_reg) >= CMP_W'(count_reg));
        stat.match    = (ram_rdata == char_reg);
        stat.more     = (idx_inc < count_reg);
        stat.more2    = (idx_inc2 < {1'b0, count_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.append) begin
            count_reg <= count_reg + 1'b1;
        end else if (cmd.dec_count) begin
            count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg  <= req_type_in;
            char_reg <= char_in;
            pos_reg  <= position_in;
        end
        if (cmd.start_scan) begin
            idx_reg <= '0;
        end else if (cmd.scan_next || cmd.shift_step) begin
            idx_reg <= idx_inc;
        end
        if (cmd.set_res) begin
            res_status_reg <= cmd.res_status;
            res_char_reg   <= cmd.res_use_rdata ? ram_rdata : '0;
        end
        if (cmd.load_out) begin
            out_status_reg <= res_status_reg;
            out_char_reg   <= res_char_reg;
            out_len_reg    <= LEN_W'(count_reg);
        end
    end

    assign status_out = out_status_reg;
    assign char_out   = out_char_reg;
    assign length_out = out_len_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");
    a_append_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.append |-> (count_reg < CNT_W'(DEPTH)))
        else $error("append into full list");
    a_dec_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.dec_count |-> (count_reg != '0))
        else $error("delete from empty list");
`endif

endmodule

// File: sv/ocl_ctrl.sv
// ----------------------------------------------------------------------------
// Ordered character list controller
// Sequences append, delete scan/shift and indexed read; owns output valid.
// ----------------------------------------------------------------------------
module ocl_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  ocl_pkg::ocl_stat_t stat,
    output ocl_pkg::ocl_cmd_t  cmd
);
    import ocl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_RD_WAIT,
        S_SCAN,
        S_SHIFT,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        cmd         = '0;
        cmd.res_status = ST_OK;
        cmd.capture = s_tvalid && s_tready;
        state_next  = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                state_next  = S_RESULT;
                cmd.set_res = 1'b1;
                priority if (stat.req_type == REQ_APPEND) begin
                    if (stat.full) begin
                        cmd.res_status = ST_FULL;
                    end else begin
                        cmd.append = 1'b1;
                    end
                end else if (stat.req_type == REQ_DELETE) begin
                    if (stat.empty) begin
                        cmd.res_status = ST_NOT_FOUND;
                    end else begin
                        cmd.set_res    = 1'b0;
                        cmd.start_scan = 1'b1;
                        state_next     = S_SCAN;
                    end
                end else if (stat.req_type == REQ_READ) begin
                    if (stat.pos_out) begin
                        cmd.res_status = ST_RANGE;
                    end else begin
                        cmd.set_res  = 1'b0;
                        cmd.read_pos = 1'b1;
                        state_next   = S_RD_WAIT;
                    end
                end else begin
                    cmd.res_status = ST_OK;
                end
            end
            S_RD_WAIT: begin
                cmd.set_res       = 1'b1;
                cmd.res_use_rdata = 1'b1;
                state_next        = S_RESULT;
            end
            S_SCAN: begin
                if (stat.match) begin
                    if (stat.more) begin
                        state_next = S_SHIFT;
                    end else begin
                        cmd.dec_count = 1'b1;
                        cmd.set_res   = 1'b1;
                        state_next    = S_RESULT;
                    end
                end else if (stat.more) begin
                    cmd.scan_next = 1'b1;
                end else begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_NOT_FOUND;
                    state_next     = S_RESULT;
                end
            end
            S_SHIFT: begin
                cmd.shift_step = 1'b1;
                if (!stat.more2) begin
                    cmd.dec_count = 1'b1;
                    cmd.set_res   = 1'b1;
                    state_next    = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("result overwrote an untaken transfer");
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while busy");
    a_result_emitted: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESULT && !m_tvalid) |=> m_tvalid)
        else $error("pending result not presented");
`endif

endmodule

// File: sv/ordered_char_list_engine.sv
// ----------------------------------------------------------------------------
// Ordered character list engine
// Keeps an ordered list of up to DEPTH characters: append, delete first
// match, read at position.
//
// Request channel (s_): s_tuser carries the request type, s_tdata the
// character and the read position. One request is taken at a time; s_tready
// is high only while the engine is idle.
// Result channel (m_): one transfer per request with status, character read
// and list length after the request.
// Append, unused request types and delete on an empty list are settled in
// the dispatch step; a read waits for the registered RAM read data; a
// delete on a non-empty list scans the entries for the match and then
// shifts the tail down, all through the single read/write port pair of
// the entry RAM.
// A finished result sits in the output register; the engine takes the next
// request while it waits, and holds its next result until the receiver
// takes the previous one.
// Reset (aresetn low, synchronous) empties the list and drops m_tvalid;
// entry RAM contents are not cleared.
// ----------------------------------------------------------------------------
module ordered_char_list_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // char_in[7:0], position[15:8]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[1:0], char_out[9:2], length[14:10], zero[15]
);
    import ocl_pkg::*;

    ocl_cmd_t          cmd;
    ocl_stat_t         stat;
    logic [1:0]        status_out;
    logic [CHAR_W-1:0] char_out;
    logic [LEN_W-1:0]  length_out;

    ocl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ocl_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_type_in (s_tuser),
        .char_in     (s_tdata[7:0]),
        .position_in (s_tdata[15:8]),
        .cmd         (cmd),
        .stat        (stat),
        .status_out  (status_out),
        .char_out    (char_out),
        .length_out  (length_out)
    );

    assign m_tdata = {1'b0, length_out, char_out, status_out};

endmodule
